// File: hdl/rational_fir_resampler_defines.svh
// Assertion macros for the rational FIR resampler.
`ifndef RATIONAL_FIR_RESAMPLER_DEFINES_SVH
`define RATIONAL_FIR_RESAMPLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clock, off during reset.
`define RFR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rational_fir_resampler: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RFR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rational_fir_resampler: assertion failed");

`else

`define RFR_ASSERT_NOW(lbl, ante, cons)
`define RFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/rfr_pkg.sv
// Shared widths, defaults and codes for the rational FIR resampler.
package rfr_pkg;

   localparam int MAX_TAPS_DEFAULT   = 64;
   localparam int MAX_INTERP_DEFAULT = 8;
   localparam int MAX_DECIM_DEFAULT  = 8;

   localparam int VALUE_W     = 16;
   localparam int COEF_IDX_W  = 6;
   localparam int INTERP_W    = 4;
   localparam int DECIM_W     = 4;
   localparam int TAPS_W      = 7;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int FRAC_BITS   = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic OP_LOAD_COEF = 1'b0;
   localparam logic OP_PUSH      = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERP = 2'd0,
      CSR_DECIM  = 2'd1,
      CSR_TAPS   = 2'd2
   } csr_index_type;

endpackage

// File: hdl/rfr_req_if.sv
// Input channel: coefficient loads and sample pushes.
interface rfr_req_if import rfr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [COEF_IDX_W-1:0]      coef_index;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, operation, coef_index, value, input ready);
   modport sink   (input valid, operation, coef_index, value, output ready);
endinterface

// File: hdl/rfr_rsp_if.sv
// Result channel: resampled output words.
interface rfr_rsp_if import rfr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  sample_out;
   logic                       last_of_run;

   modport source (output valid, sample_out, last_of_run, input ready);
   modport sink   (input valid, sample_out, last_of_run, output ready);
endinterface

// File: hdl/rfr_csr_if.sv
// Configuration write channel.
interface rfr_csr_if import rfr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/rational_fir_resampler.sv
// Rational L/M resampler: zero-stuffing FIR with one shared MAC, decimating output.
//
//  channel   dir   handshake        payload
//  req_port  in    valid / ready    operation, coef_index, value
//  rsp_port  out   valid / ready    sample_out, last_of_run
//  csr_port  in    valid / ready    index, data (always ready)
//
// A coefficient load is written straight into the coefficient memory. A push, once
// accepted, runs for each of its L zero-stuffed values one delay-line write, one step
// per tap through the single multiply-accumulate unit, a drain of the read and product
// registers and one rounding step. Reset is synchronous and empties the delay line at once.
// A result waiting in the output register stalls a rounding step that emits until taken.
`include "rational_fir_resampler_defines.svh"

module rational_fir_resampler import rfr_pkg::*; #(
   parameter int MAX_TAPS   = MAX_TAPS_DEFAULT,
   parameter int MAX_INTERP = MAX_INTERP_DEFAULT,
   parameter int MAX_DECIM  = MAX_DECIM_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rfr_req_if.sink    req_port,
   rfr_rsp_if.source  rsp_port,
   rfr_csr_if.sink    csr_port
);

   localparam int TAP_W = $clog2(MAX_TAPS);
   localparam int CNT_W = $clog2(MAX_TAPS + 1);
   localparam int L_W   = $clog2(MAX_INTERP + 1);
   localparam int M_W   = $clog2(MAX_DECIM + 1);
   localparam int PH_W  = (MAX_DECIM > 1) ? $clog2(MAX_DECIM) : 1;
   localparam int LS_W  = ((L_W > M_W) ? L_W : M_W) + 1;
   localparam int PS_W  = ((PH_W > M_W) ? PH_W : M_W) + 1;
   localparam int Q_W   = ACC_W + 1 - FRAC_BITS;
   localparam int SAT_HI = (1 << (VALUE_W - 1)) - 1;
   localparam int SAT_LO = -(1 << (VALUE_W - 1));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND
   } state_type;

   // configuration
   logic [INTERP_W-1:0] interp_ff;
   logic [DECIM_W-1:0]  decim_ff;
   logic [TAPS_W-1:0]   taps_ff;

   // sequencer
   state_type           state_ff, state_in;
   logic [L_W-1:0]      sub_ff;
   logic [PH_W-1:0]     phase_ff;
   logic [TAP_W-1:0]    wp_ff, wp_in;
   logic [TAP_W-1:0]    rp_ff;
   logic [TAP_W-1:0]    tap_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic signed [VALUE_W-1:0] sample_ff;

   // MAC pipeline
   logic                       rd_valid_ff, prod_valid_ff, rd_filled_ff;
   logic signed [VALUE_W-1:0]  coef_rd_ff, dl_rd_ff;
   logic signed [VALUE_W-1:0]  dl_term;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   // output register
   logic                       rsp_valid_ff;
   logic signed [VALUE_W-1:0]  rsp_sample_ff;
   logic                       rsp_last_ff;

   logic [VALUE_W-1:0] coef_mem [MAX_TAPS];
   logic [VALUE_W-1:0] dl_mem   [MAX_TAPS];

   logic [L_W-1:0]    l_eff;
   logic [M_W-1:0]    m_eff;
   logic [CNT_W-1:0]  n_eff;
   logic              push_acc, load_acc, emit, rsp_free, rsp_load, last_sub, last_emit;
   logic signed [ACC_W:0]     round_sum;
   logic signed [Q_W-1:0]     round_q;
   logic signed [VALUE_W-1:0] round_sat;

   // clamp configuration to usable ranges
   always_comb begin
      if (interp_ff == '0) begin
         l_eff = L_W'(1);
      end else if (interp_ff > MAX_INTERP) begin
         l_eff = L_W'(MAX_INTERP);
      end else begin
         l_eff = L_W'(interp_ff);
      end
      if (decim_ff == '0) begin
         m_eff = M_W'(1);
      end else if (decim_ff > MAX_DECIM) begin
         m_eff = M_W'(MAX_DECIM);
      end else begin
         m_eff = M_W'(decim_ff);
      end
      if (taps_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (taps_ff > MAX_TAPS) begin
         n_eff = CNT_W'(MAX_TAPS);
      end else begin
         n_eff = CNT_W'(taps_ff);
      end
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign csr_port.ready = 1'b1;
   assign push_acc = req_port.valid && req_port.ready && (req_port.operation == OP_PUSH);
   assign load_acc = req_port.valid && req_port.ready && (req_port.operation == OP_LOAD_COEF);

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.sample_out  = rsp_sample_ff;
   assign rsp_port.last_of_run = rsp_last_ff;

   assign wp_in     = (wp_ff == TAP_W'(MAX_TAPS - 1)) ? '0 : wp_ff + TAP_W'(1);
   assign emit      = (phase_ff == '0);
   assign rsp_free  = !rsp_valid_ff || rsp_port.ready;
   assign rsp_load  = (state_ff == ST_ROUND) && emit && rsp_free;
   assign last_sub  = (LS_W'(sub_ff) + LS_W'(1)) >= LS_W'(l_eff);
   // the next emit comes M values later; last if that is past the run
   assign last_emit = (LS_W'(sub_ff) + LS_W'(m_eff)) >= LS_W'(l_eff);

   // empty delay-line slots read as zero
   assign dl_term = rd_filled_ff ? dl_rd_ff : '0;

   // round half up, then saturate
   always_comb begin
      round_sum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
      round_q   = round_sum[ACC_W:FRAC_BITS];
      if (round_q > SAT_HI) begin
         round_sat = VALUE_W'(SAT_HI);
      end else if (round_q < SAT_LO) begin
         round_sat = VALUE_W'(SAT_LO);
      end else begin
         round_sat = round_q[VALUE_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (push_acc) state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_MAC;
         ST_MAC:   if (CNT_W'(tap_ff) + CNT_W'(1) == n_eff) state_in = ST_DRAIN;
         ST_DRAIN: if (!rd_valid_ff && !prod_valid_ff) state_in = ST_ROUND;
         ST_ROUND: begin
            if (!emit || rsp_free) begin
               state_in = last_sub ? ST_IDLE : ST_SHIFT;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (load_acc && (req_port.coef_index < MAX_TAPS)) begin
         coef_mem[TAP_W'(req_port.coef_index)] <= req_port.value;
      end
      if (state_ff == ST_SHIFT) begin
         dl_mem[wp_in] <= (sub_ff == '0) ? sample_ff : '0;
      end
      coef_rd_ff <= coef_mem[tap_ff];
      dl_rd_ff   <= dl_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff     <= INTERP_W'(1);
         decim_ff      <= DECIM_W'(1);
         taps_ff       <= TAPS_W'(64);
         state_ff      <= ST_IDLE;
         sub_ff        <= '0;
         phase_ff      <= '0;
         wp_ff         <= '0;
         fill_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_port.valid) begin
            case (csr_index_type'(csr_port.index))
               CSR_INTERP: interp_ff <= csr_port.data[INTERP_W-1:0];
               CSR_DECIM:  decim_ff  <= csr_port.data[DECIM_W-1:0];
               CSR_TAPS:   taps_ff   <= csr_port.data[TAPS_W-1:0];
               default:    ;
            endcase
         end

         state_ff      <= state_in;
         rd_valid_ff   <= (state_ff == ST_MAC);
         prod_valid_ff <= rd_valid_ff;

         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_sample_ff <= round_sat;
            rsp_last_ff   <= last_emit;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (push_acc) begin
                  sample_ff <= req_port.value;
                  sub_ff    <= '0;
               end
            end
            ST_SHIFT: begin
               wp_ff  <= wp_in;
               rp_ff  <= wp_in;
               tap_ff <= '0;
               acc_ff <= '0;
               if (fill_ff != CNT_W'(MAX_TAPS)) begin
                  fill_ff <= fill_ff + CNT_W'(1);
               end
            end
            ST_MAC: begin
               rd_filled_ff <= (CNT_W'(tap_ff) < fill_ff);
               tap_ff       <= tap_ff + TAP_W'(1);
               rp_ff        <= (rp_ff == '0) ? TAP_W'(MAX_TAPS - 1) : rp_ff - TAP_W'(1);
            end
            ST_DRAIN: ;
            ST_ROUND: begin
               if (!emit || rsp_free) begin
                  if ((PS_W'(phase_ff) + PS_W'(1)) >= PS_W'(m_eff)) begin
                     phase_ff <= '0;
                  end else begin
                     phase_ff <= phase_ff + PH_W'(1);
                  end
                  sub_ff <= last_sub ? '0 : sub_ff + L_W'(1);
               end
            end
            default: ;
         endcase

         if (rd_valid_ff) begin
            prod_ff <= coef_rd_ff * dl_term;
         end
         if (prod_valid_ff) begin
            acc_ff <= acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end
   end

   `RFR_ASSERT_NEXT(a_push_starts_shift, push_acc, state_ff == ST_SHIFT)
   `RFR_ASSERT_NOW(a_tap_in_range, state_ff == ST_MAC, CNT_W'(tap_ff) < n_eff)
   `RFR_ASSERT_NOW(a_sub_in_range, state_ff != ST_IDLE, sub_ff < l_eff)
   `RFR_ASSERT_NEXT(a_emit_loads_output, rsp_load, rsp_valid_ff)

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the rational L/M FIR resampler.
module testbench;
   import rfr_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int WORDS_PER_BLOCK = 24;
   localparam int BLOCKS_PER_REGIME = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7fff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;

   typedef struct {
      logic signed [VALUE_W-1:0] sample;
      logic                      last;
   } out_word_type;

   logic clock;
   logic reset;

   rfr_req_if req_bus ();
   rfr_rsp_if rsp_bus ();
   rfr_csr_if csr_bus ();

   rational_fir_resampler uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Mirror of the block state
   logic signed [VALUE_W-1:0] tap_coef [MAX_TAPS_DEFAULT];
   logic signed [VALUE_W-1:0] delay_taps [MAX_TAPS_DEFAULT];
   logic [2:0]                phase_q;
   logic [INTERP_W-1:0]       interp_setting;
   logic [DECIM_W-1:0]        decim_setting;
   logic [TAPS_W-1:0]         taps_setting;

   out_word_type pending_outputs [$];
   out_word_type head_word;

   int send_idle_pct = 30;
   int recv_idle_pct = 61;
   int error_count = 0;
   int words_checked = 0;
   int pushes_sent = 0;
   int loads_sent = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned bounded(int unsigned raw, int unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic logic signed [VALUE_W-1:0] filter_output(int unsigned ntaps);
      logic signed [ACC_W-1:0]  acc;
      logic signed [PROD_W-1:0] prod;
      longint                   rounded;
      acc = '0;
      for (int k = 0; k < ntaps; k++) begin
         prod = tap_coef[k] * delay_taps[k];
         acc = acc + prod;
      end
      // round half up, then saturate
      rounded = (longint'(acc) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (rounded > 32767) return VALUE_MAX;
      if (rounded < -32768) return VALUE_MIN;
      return rounded[VALUE_W-1:0];
   endfunction

   task automatic predict_push(input logic signed [VALUE_W-1:0] sample);
      int unsigned  up, down, ntaps;
      out_word_type fresh [$];
      out_word_type w;
      up = bounded(interp_setting, MAX_INTERP_DEFAULT);
      down = bounded(decim_setting, MAX_DECIM_DEFAULT);
      ntaps = bounded(taps_setting, MAX_TAPS_DEFAULT);
      for (int j = 0; j < up; j++) begin
         for (int k = MAX_TAPS_DEFAULT - 1; k > 0; k--) delay_taps[k] = delay_taps[k-1];
         delay_taps[0] = (j == 0) ? sample : '0;
         w.sample = filter_output(ntaps);
         w.last = 1'b0;
         if (phase_q == 0) fresh.push_back(w);
         // a phase left above a lowered factor emits nothing and wraps to zero
         if (int'(phase_q) + 1 >= down) phase_q = '0;
         else phase_q = phase_q + 3'd1;
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) pending_outputs.push_back(fresh[i]);
   endtask

   function automatic int settle_cycles();
      return bounded(interp_setting, MAX_INTERP_DEFAULT)
             * (bounded(taps_setting, MAX_TAPS_DEFAULT) + 5) + 20;
   endfunction

   task automatic send_word(input logic op, input logic [COEF_IDX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.coef_index <= idx;
      req_bus.value <= val;
      do @(posedge clock); while (!req_bus.ready);
      if (op == OP_PUSH) begin
         predict_push(val);
         pushes_sent++;
      end else begin
         tap_coef[idx] = val;
         loads_sent++;
      end
   endtask

   task automatic push_sample(input logic signed [VALUE_W-1:0] val);
      send_word(OP_PUSH, COEF_IDX_W'($urandom), val);
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_outputs.size() != 0);
   endtask

   // Hold the input until the block has gone quiet
   task automatic settle();
      hold_until_drained();
      repeat (settle_cycles()) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_INTERP: interp_setting = data[INTERP_W-1:0];
         CSR_DECIM:  decim_setting = data[DECIM_W-1:0];
         CSR_TAPS:   taps_setting = data[TAPS_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_factor();
      if ($urandom_range(7) == 0) return CSR_DATA_W'($urandom_range(255));
      return CSR_DATA_W'($urandom_range(1, MAX_INTERP_DEFAULT));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_tap_count();
      if ($urandom_range(7) == 0) return CSR_DATA_W'($urandom_range(255));
      if ($urandom_range(9) == 0) return CSR_DATA_W'(MAX_TAPS_DEFAULT);
      return CSR_DATA_W'($urandom_range(1, 16));
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(15))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Every tap gets written before any push can read it
   task automatic test_coefficient_fill();
      logic signed [VALUE_W-1:0] val;
      for (int i = 0; i < MAX_TAPS_DEFAULT; i++) begin
         if (i == 0) val = VALUE_MAX;
         else if (i == MAX_TAPS_DEFAULT - 1) val = VALUE_MIN;
         else val = VALUE_W'($urandom);
         send_word(OP_LOAD_COEF, COEF_IDX_W'(i), val);
      end
   endtask

   task automatic test_push_extremes();
      push_sample(VALUE_MAX);
      push_sample(VALUE_MIN);
      push_sample('0);
   endtask

   task automatic test_saturation_rounding();
      settle();
      write_setting(CSR_TAPS, 8'd2);
      send_word(OP_LOAD_COEF, 6'd0, VALUE_MIN);
      send_word(OP_LOAD_COEF, 6'd1, VALUE_MIN);
      push_sample(VALUE_MIN);
      push_sample(VALUE_MIN);
      push_sample(VALUE_MAX);
      push_sample(VALUE_MAX);
      // unit tap: exact halves round up, just below half rounds down
      settle();
      write_setting(CSR_TAPS, 8'd1);
      send_word(OP_LOAD_COEF, 6'd0, 16'sd1);
      push_sample(16'sd16384);
      push_sample(-16'sd16384);
      push_sample(16'sd16383);
      push_sample(-16'sd16385);
   endtask

   task automatic test_register_limits();
      settle();
      write_setting(CSR_INTERP, 8'd0);
      write_setting(CSR_DECIM, 8'd0);
      write_setting(CSR_TAPS, 8'd0);
      push_sample(pick_value());
      settle();
      write_setting(CSR_INTERP, 8'hff);
      write_setting(CSR_DECIM, 8'hff);
      write_setting(CSR_TAPS, 8'hff);
      push_sample(VALUE_MAX);
      push_sample(VALUE_MIN);
      settle();
      write_setting(CSR_UNUSED_INDEX, 8'hff);
      push_sample(pick_value());
   endtask

   task automatic test_phase_carry();
      settle();
      write_setting(CSR_INTERP, 8'd3);
      write_setting(CSR_DECIM, 8'd8);
      write_setting(CSR_TAPS, 8'd8);
      push_sample(pick_value());
      // phase now sits above the new factor
      settle();
      write_setting(CSR_DECIM, 8'd2);
      push_sample(pick_value());
      send_word(OP_LOAD_COEF, 6'd5, pick_value());
      settle();
      write_setting(CSR_INTERP, 8'd1);
      write_setting(CSR_DECIM, 8'd4);
      repeat (4) push_sample(pick_value());
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (BLOCKS_PER_REGIME) begin
         settle();
         write_setting(CSR_INTERP, pick_factor());
         write_setting(CSR_DECIM, pick_factor());
         write_setting(CSR_TAPS, pick_tap_count());
         repeat (WORDS_PER_BLOCK) begin
            if ($urandom_range(99) < 15)
               send_word(OP_LOAD_COEF, COEF_IDX_W'($urandom), VALUE_W'($urandom));
            else
               push_sample(pick_value());
            if ($urandom_range(49) == 0) hold_until_drained();
         end
      end
   endtask

   // Result side: random backpressure and in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outputs.size() == 0) begin
               $error("output word with none expected: sample_out %0d last_of_run %0b",
                      rsp_bus.sample_out, rsp_bus.last_of_run);
               error_count++;
            end else begin
               head_word = pending_outputs.pop_front();
               words_checked++;
               if (rsp_bus.sample_out !== head_word.sample) begin
                  $error("sample_out: expected %0d, got %0d",
                         head_word.sample, rsp_bus.sample_out);
                  error_count++;
               end
               if (rsp_bus.last_of_run !== head_word.last) begin
                  $error("last_of_run: expected %0b, got %0b",
                         head_word.last, rsp_bus.last_of_run);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_PUSH;
      req_bus.coef_index = '0;
      req_bus.value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_INTERP;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      interp_setting = 4'd1;
      decim_setting = 4'd1;
      taps_setting = 7'(MAX_TAPS_DEFAULT);
      phase_q = '0;
      foreach (delay_taps[i]) delay_taps[i] = '0;
      foreach (tap_coef[i]) tap_coef[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_coefficient_fill();
      test_push_extremes();
      test_saturation_rounding();
      test_register_limits();
      test_phase_carry();
      test_random_traffic(30, 61);
      test_random_traffic(61, 30);
      test_random_traffic(0, 0);

      settle();
      $display("testbench: ran %0d sample pushes and %0d coefficient loads over mixed L/M",
               pushes_sent, loads_sent);
      $display("testbench: compared %0d output words, %0d mismatches",
               words_checked, error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rfr_pkg.sv
hdl/rfr_req_if.sv
hdl/rfr_rsp_if.sv
hdl/rfr_csr_if.sv
hdl/rational_fir_resampler.sv
bench/testbench.sv
